>>> hw/rtl/tlr_pkg.sv
package tlr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int ERR_W          = 13;
  localparam int RECT_W         = 13;
  localparam int SIDE_W         = 7;
  localparam int COLOR_W        = 16;
  localparam int THICK_W        = 8;
  localparam int OUT_FIELDS_W   = 2 * RECT_W + SIDE_W + COLOR_W;
  localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_INC  = 2'd1;
  localparam logic [1:0] DIR_DEC  = 2'd3;

  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic [COLOR_W-1:0]        color;
    logic [SIDE_W-1:0]         side;
    logic signed [RECT_W-1:0]  y;
    logic signed [RECT_W-1:0]  x;
  } tlr_point_t;

endpackage

>>> hw/rtl/tlr_step.sv
module tlr_step #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF
) (
  input  logic                              req_type,
  input  logic [COORD_BITS-1:0]             x_start,
  input  logic [COORD_BITS-1:0]             y_start,
  input  logic [COORD_BITS-1:0]             x_end,
  input  logic [COORD_BITS-1:0]             y_end,
  input  logic [tlr_pkg::COLOR_W-1:0]       pen_color,
  input  logic signed [tlr_pkg::THICK_W-1:0] pen_thickness,
  input  logic                              active,
  input  logic [COORD_BITS-1:0]             cur_col,
  input  logic [COORD_BITS-1:0]             cur_row,
  input  logic [1:0]                        dir_col,
  input  logic [1:0]                        dir_row,
  input  logic [COORD_BITS-1:0]             abs_dcol,
  input  logic [COORD_BITS-1:0]             abs_drow,
  input  logic [COORD_BITS-1:0]             major_len,
  input  logic [tlr_pkg::ERR_W-1:0]         err_col,
  input  logic [tlr_pkg::ERR_W-1:0]         err_row,
  input  logic [tlr_pkg::ERR_W-1:0]         points_left,
  input  logic [tlr_pkg::COLOR_W-1:0]       line_color,
  input  logic [tlr_pkg::SIDE_W-1:0]        line_thick,
  output logic                              active_nxt,
  output logic [COORD_BITS-1:0]             cur_col_nxt,
  output logic [COORD_BITS-1:0]             cur_row_nxt,
  output logic [1:0]                        dir_col_nxt,
  output logic [1:0]                        dir_row_nxt,
  output logic [COORD_BITS-1:0]             abs_dcol_nxt,
  output logic [COORD_BITS-1:0]             abs_drow_nxt,
  output logic [COORD_BITS-1:0]             major_len_nxt,
  output logic [tlr_pkg::ERR_W-1:0]         err_col_nxt,
  output logic [tlr_pkg::ERR_W-1:0]         err_row_nxt,
  output logic [tlr_pkg::ERR_W-1:0]         points_left_nxt,
  output logic [tlr_pkg::COLOR_W-1:0]       line_color_nxt,
  output logic [tlr_pkg::SIDE_W-1:0]        line_thick_nxt,
  output tlr_pkg::tlr_point_t               point
);

  localparam int ERR_W  = tlr_pkg::ERR_W;
  localparam int RECT_W = tlr_pkg::RECT_W;
  localparam int SIDE_W = tlr_pkg::SIDE_W;
  localparam int EW = ((COORD_BITS > ERR_W) ? COORD_BITS : ERR_W) + 1;
  localparam int RW = (COORD_BITS > RECT_W) ? COORD_BITS : RECT_W;

  logic                   is_start;
  logic                   thick_ok;
  logic                   emit;
  logic [1:0]             ld_dir_col, ld_dir_row;
  logic [COORD_BITS-1:0]  ld_abs_col, ld_abs_row, ld_major;
  logic [EW-1:0]          ld_left_sum;

  logic [COORD_BITS-1:0]  s_col, s_row, s_abs_col, s_abs_row, s_major;
  logic [1:0]             s_dir_col, s_dir_row;
  logic [ERR_W-1:0]       s_err_col, s_err_row, s_left;
  logic [tlr_pkg::COLOR_W-1:0] s_color;
  logic [SIDE_W-1:0]      s_thick;

  logic                   last;
  logic [EW-1:0]          sum_col, sum_row, sub_col, sub_row;
  logic [ERR_W-1:0]       acc_col, acc_row;
  logic                   step_col, step_row;
  logic [COORD_BITS-1:0]  mv_col, mv_row;
  logic [ERR_W-1:0]       left_dec;
  logic [SIDE_W-2:0]      half;
  logic [RW-1:0]          rx_full, ry_full;

  assign is_start = (req_type == tlr_pkg::REQ_START);
  assign thick_ok = !pen_thickness[tlr_pkg::THICK_W-1] && (pen_thickness != '0);
  assign emit     = is_start ? thick_ok : active;

  always_comb begin
    if (x_end > x_start) begin
      ld_dir_col = tlr_pkg::DIR_INC;
      ld_abs_col = x_end - x_start;
    end else if (x_end < x_start) begin
      ld_dir_col = tlr_pkg::DIR_DEC;
      ld_abs_col = x_start - x_end;
    end else begin
      ld_dir_col = tlr_pkg::DIR_HOLD;
      ld_abs_col = '0;
    end
    if (y_end > y_start) begin
      ld_dir_row = tlr_pkg::DIR_INC;
      ld_abs_row = y_end - y_start;
    end else if (y_end < y_start) begin
      ld_dir_row = tlr_pkg::DIR_DEC;
      ld_abs_row = y_start - y_end;
    end else begin
      ld_dir_row = tlr_pkg::DIR_HOLD;
      ld_abs_row = '0;
    end
  end

  assign ld_major    = (ld_abs_col > ld_abs_row) ? ld_abs_col : ld_abs_row;
  assign ld_left_sum = EW'(ld_major) + EW'(1);

  always_comb begin
    if (is_start) begin
      s_col     = x_start;
      s_row     = y_start;
      s_dir_col = ld_dir_col;
      s_dir_row = ld_dir_row;
      s_abs_col = ld_abs_col;
      s_abs_row = ld_abs_row;
      s_major   = ld_major;
      s_err_col = '0;
      s_err_row = '0;
      s_left    = ld_left_sum[ERR_W-1:0];
      s_color   = pen_color;
      s_thick   = pen_thickness[SIDE_W-1:0];
    end else begin
      s_col     = cur_col;
      s_row     = cur_row;
      s_dir_col = dir_col;
      s_dir_row = dir_row;
      s_abs_col = abs_dcol;
      s_abs_row = abs_drow;
      s_major   = major_len;
      s_err_col = err_col;
      s_err_row = err_row;
      s_left    = points_left;
      s_color   = line_color;
      s_thick   = line_thick;
    end
  end

  assign last     = (s_left == '0);
  assign sum_col  = EW'(s_err_col) + EW'(s_abs_col);
  assign sum_row  = EW'(s_err_row) + EW'(s_abs_row);
  assign acc_col  = sum_col[ERR_W-1:0];
  assign acc_row  = sum_row[ERR_W-1:0];
  assign step_col = EW'(acc_col) > EW'(s_major);
  assign step_row = EW'(acc_row) > EW'(s_major);
  assign sub_col  = EW'(acc_col) - EW'(s_major);
  assign sub_row  = EW'(acc_row) - EW'(s_major);
  assign left_dec = s_left - ERR_W'(1);

  always_comb begin
    case (s_dir_col)
      tlr_pkg::DIR_INC: mv_col = s_col + COORD_BITS'(1);
      tlr_pkg::DIR_DEC: mv_col = s_col - COORD_BITS'(1);
      default:          mv_col = s_col;
    endcase
    case (s_dir_row)
      tlr_pkg::DIR_INC: mv_row = s_row + COORD_BITS'(1);
      tlr_pkg::DIR_DEC: mv_row = s_row - COORD_BITS'(1);
      default:          mv_row = s_row;
    endcase
  end

  assign half    = s_thick[SIDE_W-1:1];
  assign rx_full = RW'(s_col) - RW'(half);
  assign ry_full = RW'(s_row) - RW'(half);

  always_comb begin
    active_nxt      = active;
    cur_col_nxt     = cur_col;
    cur_row_nxt     = cur_row;
    dir_col_nxt     = dir_col;
    dir_row_nxt     = dir_row;
    abs_dcol_nxt    = abs_dcol;
    abs_drow_nxt    = abs_drow;
    major_len_nxt   = major_len;
    err_col_nxt     = err_col;
    err_row_nxt     = err_row;
    points_left_nxt = points_left;
    line_color_nxt  = line_color;
    line_thick_nxt  = line_thick;
    point           = '0;
    if (is_start && !thick_ok) begin
      active_nxt = 1'b0;
    end else if (emit) begin
      point.valid     = 1'b1;
      point.last      = last;
      point.color     = s_color;
      point.side      = s_thick;
      point.x         = rx_full[RECT_W-1:0];
      point.y         = ry_full[RECT_W-1:0];
      active_nxt      = !last;
      cur_col_nxt     = s_col;
      cur_row_nxt     = s_row;
      dir_col_nxt     = s_dir_col;
      dir_row_nxt     = s_dir_row;
      abs_dcol_nxt    = s_abs_col;
      abs_drow_nxt    = s_abs_row;
      major_len_nxt   = s_major;
      err_col_nxt     = s_err_col;
      err_row_nxt     = s_err_row;
      points_left_nxt = s_left;
      line_color_nxt  = s_color;
      line_thick_nxt  = s_thick;
      if (!last) begin
        err_col_nxt     = step_col ? sub_col[ERR_W-1:0] : acc_col;
        err_row_nxt     = step_row ? sub_row[ERR_W-1:0] : acc_row;
        cur_col_nxt     = step_col ? mv_col : s_col;
        cur_row_nxt     = step_row ? mv_row : s_row;
        points_left_nxt = left_dec;
      end
    end
  end

endmodule

>>> hw/rtl/thick_line_rasterizer.sv
// Channel | Dir | tdata / tuser / tlast
// in_     | in  | request: line start or advance, end points, color, thickness
// out_    | out | one result per request (out_tuser marks a pen square), tlast on the final point
//
// One request per cycle sustained while out_tready is high.
// Stage one registers the request, stage two steps the line state and the result register.
// rst_n is synchronous and clears the valid flags and the active-line flag.
// A stalled result holds; in_tready drops only while both stages are full and stalled.
module thick_line_rasterizer #(
  parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // x_start, y_start, x_end, y_end, pen_color, pen_thickness
  input  logic [((4*COORD_BITS+tlr_pkg::COLOR_W+tlr_pkg::THICK_W+7)/8)*8-1:0] in_tdata,
  // req_type
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // rect_x, rect_y, rect_side, rect_color
  output logic [tlr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // point_valid
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int CB      = COORD_BITS;
  localparam int COLOR_W = tlr_pkg::COLOR_W;
  localparam int THICK_W = tlr_pkg::THICK_W;
  localparam int ERR_W   = tlr_pkg::ERR_W;
  localparam int SIDE_W  = tlr_pkg::SIDE_W;
  localparam int IN_DATA_W = ((4*CB + COLOR_W + THICK_W + 7) / 8) * 8;

  logic                   s1_valid_r;
  logic                   s1_type_r;
  logic [IN_DATA_W-1:0]   s1_data_r;
  logic                   s1_go;

  logic                   out_valid_r;
  tlr_pkg::tlr_point_t    point_r;
  tlr_pkg::tlr_point_t    step_pt;

  logic                   active_r, active_nxt;
  logic [CB-1:0]          cur_col_r, cur_col_nxt, cur_row_r, cur_row_nxt;
  logic [1:0]             dir_col_r, dir_col_nxt, dir_row_r, dir_row_nxt;
  logic [CB-1:0]          abs_dcol_r, abs_dcol_nxt, abs_drow_r, abs_drow_nxt;
  logic [CB-1:0]          major_len_r, major_len_nxt;
  logic [ERR_W-1:0]       err_col_r, err_col_nxt, err_row_r, err_row_nxt;
  logic [ERR_W-1:0]       points_left_r, points_left_nxt;
  logic [COLOR_W-1:0]     line_color_r, line_color_nxt;
  logic [SIDE_W-1:0]      line_thick_r, line_thick_nxt;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_type_r <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  tlr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .req_type        (s1_type_r),
    .x_start         (s1_data_r[CB-1:0]),
    .y_start         (s1_data_r[2*CB-1:CB]),
    .x_end           (s1_data_r[3*CB-1:2*CB]),
    .y_end           (s1_data_r[4*CB-1:3*CB]),
    .pen_color       (s1_data_r[4*CB+COLOR_W-1:4*CB]),
    .pen_thickness   (s1_data_r[4*CB+COLOR_W+THICK_W-1:4*CB+COLOR_W]),
    .active          (active_r),
    .cur_col         (cur_col_r),
    .cur_row         (cur_row_r),
    .dir_col         (dir_col_r),
    .dir_row         (dir_row_r),
    .abs_dcol        (abs_dcol_r),
    .abs_drow        (abs_drow_r),
    .major_len       (major_len_r),
    .err_col         (err_col_r),
    .err_row         (err_row_r),
    .points_left     (points_left_r),
    .line_color      (line_color_r),
    .line_thick      (line_thick_r),
    .active_nxt      (active_nxt),
    .cur_col_nxt     (cur_col_nxt),
    .cur_row_nxt     (cur_row_nxt),
    .dir_col_nxt     (dir_col_nxt),
    .dir_row_nxt     (dir_row_nxt),
    .abs_dcol_nxt    (abs_dcol_nxt),
    .abs_drow_nxt    (abs_drow_nxt),
    .major_len_nxt   (major_len_nxt),
    .err_col_nxt     (err_col_nxt),
    .err_row_nxt     (err_row_nxt),
    .points_left_nxt (points_left_nxt),
    .line_color_nxt  (line_color_nxt),
    .line_thick_nxt  (line_thick_nxt),
    .point           (step_pt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (s1_go) begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      cur_col_r     <= cur_col_nxt;
      cur_row_r     <= cur_row_nxt;
      dir_col_r     <= dir_col_nxt;
      dir_row_r     <= dir_row_nxt;
      abs_dcol_r    <= abs_dcol_nxt;
      abs_drow_r    <= abs_drow_nxt;
      major_len_r   <= major_len_nxt;
      err_col_r     <= err_col_nxt;
      err_row_r     <= err_row_nxt;
      points_left_r <= points_left_nxt;
      line_color_r  <= line_color_nxt;
      line_thick_r  <= line_thick_nxt;
      point_r       <= step_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = point_r.valid;
  assign out_tlast  = point_r.last;
  assign out_tdata  = tlr_pkg::OUT_DATA_W'({point_r.color, point_r.side, point_r.y, point_r.x});

  a_last_on_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last point flagged on an empty result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata == '0))
    else $error("empty result carries nonzero fields");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && step_pt.valid && step_pt.last |=> !active_r)
    else $error("line still active after its last point");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

endmodule
